### rtl/pfa_pkg.sv
// Shared types and codes for the prime field ALU.
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam int unsigned FW = 31;   // field element width

    // classified item header passed from front to back
    typedef struct packed {
        logic [1:0] op;
        logic       neg_a;
        logic       neg_b;
    } t_item_hdr;

endpackage
`default_nettype wire

### rtl/pfa_front.sv
// Front end: accepts items, splits operands into sign and magnitude, queues them.
`timescale 1ns / 1ps
`default_nettype none
module pfa_front #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [1:0]                   i_op,
    input  wire  signed [DATA_WIDTH-1:0] i_left_operand,
    input  wire  signed [DATA_WIDTH-1:0] i_right_operand,
    output logic                         o_q_valid,
    input  wire                          i_q_pop,
    output pfa_pkg::t_item_hdr           o_q_hdr,
    output logic [DATA_WIDTH-1:0]        o_q_mag_a,
    output logic [DATA_WIDTH-1:0]        o_q_mag_b
);

    pfa_pkg::t_item_hdr    r_hdr   [2];
    logic [DATA_WIDTH-1:0] r_mag_a [2];
    logic [DATA_WIDTH-1:0] r_mag_b [2];
    logic [1:0]            r_cnt, n_cnt;
    logic                  r_wp, r_rp;
    logic                  w_push, w_pop;
    pfa_pkg::t_item_hdr    w_hdr;
    logic [DATA_WIDTH-1:0] w_mag_a, w_mag_b;

    always_comb begin
        w_hdr.op    = i_op;
        w_hdr.neg_a = i_left_operand[DATA_WIDTH-1];
        w_hdr.neg_b = i_right_operand[DATA_WIDTH-1];
        // negating the most negative value gives its magnitude as unsigned
        w_mag_a = w_hdr.neg_a ? (~i_left_operand + 1'b1) : i_left_operand;
        w_mag_b = w_hdr.neg_b ? (~i_right_operand + 1'b1) : i_right_operand;
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_hdr    = r_hdr[r_rp];
    assign o_q_mag_a  = r_mag_a[r_rp];
    assign o_q_mag_b  = r_mag_b[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_hdr[r_wp]   <= w_hdr;
            r_mag_a[r_wp] <= w_mag_a;
            r_mag_b[r_wp] <= w_mag_b;
        end
    end

endmodule
`default_nettype wire

### rtl/pfa_back.sv
// Back end: operand reduction, field add/sub/mul, and extended Euclid inverse.
`timescale 1ns / 1ps
`default_nettype none
module pfa_back #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire  [30:0]            i_modulus,
    input  wire                    i_q_valid,
    output logic                   o_q_pop,
    input  wire  pfa_pkg::t_item_hdr i_q_hdr,
    input  wire  [DATA_WIDTH-1:0]  i_q_mag_a,
    input  wire  [DATA_WIDTH-1:0]  i_q_mag_b,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic [30:0]            o_result,
    output logic                   o_divide_by_zero
);

    localparam int NW = (DATA_WIDTH > 31) ? DATA_WIDTH : 31;
    localparam int CW = $clog2(NW);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RED   = 4'd1;
    localparam logic [3:0] S_OPS   = 4'd2;
    localparam logic [3:0] S_ECHK  = 4'd3;
    localparam logic [3:0] S_EDIV  = 4'd4;
    localparam logic [3:0] S_IFIX  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0]             r_state;
    pfa_pkg::t_item_hdr     r_hdr;
    logic [DATA_WIDTH-1:0]  r_mag_b;
    logic                   r_which;        // 0 reducing a, 1 reducing b
    logic [NW-1:0]          r_dvd;
    logic [31:0]            r_rem;
    logic [30:0]            r_dvs;
    logic [CW-1:0]          r_cnt;
    logic [30:0]            r_a, r_b;
    logic [30:0]            r_ea, r_em;
    logic signed [63:0]     r_x0, r_x1, r_acc, r_sx;
    logic [30:0]            r_ma, r_mb, r_macc;
    logic [30:0]            r_res;
    logic                   r_dz;
    logic                   r_out_valid;

    logic [30:0]            w_pm;
    logic [31:0]            w_t, n_rem;
    logic                   w_take;
    logic [30:0]            w_red;
    logic [31:0]            w_sum, w_add;
    logic [31:0]            w_m1, w_m2, w_m1r;
    logic [30:0]            w_mnext;
    logic signed [63:0]     w_inv0, w_inv1;
    logic                   w_load;

    assign w_pm = (i_modulus < 31'd2) ? 31'd1 : i_modulus;

    // one restoring division step
    always_comb begin
        w_t    = {r_rem[30:0], r_dvd[NW-1]};
        w_take = (w_t >= {1'b0, r_dvs});
        n_rem  = w_take ? (w_t - {1'b0, r_dvs}) : w_t;
    end

    // floored modulo fixup for negative operands
    always_comb begin
        w_red = n_rem[30:0];
        if ((r_which ? r_hdr.neg_b : r_hdr.neg_a) && (w_red != 31'd0)) begin
            w_red = w_pm - w_red;
        end
    end

    always_comb begin
        w_sum = (r_hdr.op == pfa_pkg::OP_ADD) ? ({1'b0, r_a} + {1'b0, r_b})
                                              : ({1'b0, r_a} + {1'b0, w_pm} - {1'b0, r_b});
        w_add = (w_sum >= {1'b0, w_pm}) ? (w_sum - {1'b0, w_pm}) : w_sum;
    end

    // shift-add modular multiply step, msb of multiplier first
    always_comb begin
        w_m1  = {r_macc, 1'b0};
        w_m1r = (w_m1 >= {1'b0, w_pm}) ? (w_m1 - {1'b0, w_pm}) : w_m1;
        w_m2  = w_m1r + (r_mb[30] ? {1'b0, r_ma} : 32'd0);
        w_mnext = (w_m2 >= {1'b0, w_pm}) ? 31'(w_m2 - {1'b0, w_pm}) : w_m2[30:0];
    end

    always_comb begin
        w_inv0 = (r_x1 < 0) ? (r_x1 + $signed({33'd0, w_pm})) : r_x1;
        w_inv1 = (w_inv0 >= $signed({33'd0, w_pm})) ? (w_inv0 - $signed({33'd0, w_pm}))
                                                     : w_inv0;
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign w_load  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (i_q_valid) r_state <= S_RED;
                S_RED: begin
                    if (r_cnt == '0 && r_which) r_state <= S_OPS;
                end
                S_OPS: begin
                    case (r_hdr.op)
                        pfa_pkg::OP_MUL: r_state <= S_MUL;
                        pfa_pkg::OP_DIV: r_state <= (r_b == 31'd0) ? S_DONE : S_ECHK;
                        default:         r_state <= S_DONE;
                    endcase
                end
                S_ECHK: r_state <= (r_ea > 31'd1 && r_em != 31'd0) ? S_EDIV : S_IFIX;
                S_EDIV: if (r_cnt == '0) r_state <= S_ECHK;
                S_IFIX: r_state <= S_MUL;
                S_MUL:  if (r_cnt == '0) r_state <= S_DONE;
                S_DONE: if (w_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_hdr   <= i_q_hdr;
                r_mag_b <= i_q_mag_b;
                r_which <= 1'b0;
                r_dvd   <= NW'(i_q_mag_a);
                r_rem   <= 32'd0;
                r_dvs   <= w_pm;
                r_cnt   <= CW'(NW - 1);
            end
            S_RED: begin
                r_dvd <= {r_dvd[NW-2:0], 1'b0};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    if (!r_which) begin
                        r_a     <= w_red;
                        r_which <= 1'b1;
                        r_dvd   <= NW'(r_mag_b);
                        r_rem   <= 32'd0;
                        r_cnt   <= CW'(NW - 1);
                    end else begin
                        r_b <= w_red;
                    end
                end
            end
            S_OPS: begin
                r_res <= w_add[30:0];
                r_dz  <= 1'b0;
                r_ma  <= r_a;
                r_mb  <= r_b;
                r_macc <= 31'd0;
                r_cnt <= CW'(30);
                r_ea  <= r_b;
                r_em  <= w_pm;
                r_x0  <= 64'sd0;
                r_x1  <= 64'sd1;
                if (r_hdr.op == pfa_pkg::OP_DIV && r_b == 31'd0) begin
                    r_res <= 31'd0;
                    r_dz  <= 1'b1;
                end
            end
            S_ECHK: begin
                // dividend in the top 31 bits of the shift register
                r_dvd <= NW'(r_ea) << (NW - 31);
                r_rem <= 32'd0;
                r_dvs <= r_em;
                r_cnt <= CW'(30);
                r_acc <= r_x1;
                r_sx  <= r_x0 <<< 30;
            end
            S_EDIV: begin
                r_dvd <= {r_dvd[NW-2:0], 1'b0};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                r_sx  <= r_sx >>> 1;
                if (w_take) r_acc <= r_acc - r_sx;
                if (r_cnt == '0) begin
                    r_ea <= r_em;
                    r_em <= n_rem[30:0];
                    r_x1 <= r_x0;
                    r_x0 <= w_take ? (r_acc - r_sx) : r_acc;
                end
            end
            S_IFIX: begin
                r_ma   <= r_a;
                r_mb   <= w_inv1[30:0];
                r_macc <= 31'd0;
                r_cnt  <= CW'(30);
            end
            S_MUL: begin
                r_macc <= w_mnext;
                r_mb   <= {r_mb[29:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) r_res <= w_mnext;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_result         <= r_res;
            o_divide_by_zero <= r_dz;
        end
    end

    assign o_out_valid = r_out_valid;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_RED))
        else $error("pop did not start reduction");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_out_valid && r_state == S_IDLE))
        else $error("result load lost");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_dz) |=> (o_result == 31'd0))
        else $error("divide by zero with nonzero result");

endmodule
`default_nettype wire

### rtl/prime_field_alu.sv
// Top level of the prime field ALU: modulus register, front end and back end.
`timescale 1ns / 1ps
`default_nettype none
// Computes add, subtract, multiply or divide over GF(p), p taken from the modulus
// register (values below 2 act as 1). One item at a time runs in the back end;
// a two-entry queue in front keeps accepting until it is full. Each item first
// has both operands reduced with a bit-serial divider; then add or subtract is
// done directly, multiply runs shift-add, and divide runs a setup step, Euclid
// iterations (one quotient bit a cycle) and a final multiply, before handoff.
// Write the modulus only with no items in flight.
module prime_field_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [30:0]                  i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [1:0]                   i_op,
    input  wire  signed [DATA_WIDTH-1:0] i_left_operand,
    input  wire  signed [DATA_WIDTH-1:0] i_right_operand,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [30:0]                  o_result,
    output logic                         o_divide_by_zero
);

    logic [30:0]           r_modulus;
    logic                  w_q_valid, w_q_pop;
    pfa_pkg::t_item_hdr    w_q_hdr;
    logic [DATA_WIDTH-1:0] w_q_mag_a, w_q_mag_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= 31'h7FFF_FFFF;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    pfa_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_left_operand  (i_left_operand),
        .i_right_operand (i_right_operand),
        .o_q_valid       (w_q_valid),
        .i_q_pop         (w_q_pop),
        .o_q_hdr         (w_q_hdr),
        .o_q_mag_a       (w_q_mag_a),
        .o_q_mag_b       (w_q_mag_b)
    );

    pfa_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_modulus        (r_modulus),
        .i_q_valid        (w_q_valid),
        .o_q_pop          (w_q_pop),
        .i_q_hdr          (w_q_hdr),
        .i_q_mag_a        (w_q_mag_a),
        .i_q_mag_b        (w_q_mag_b),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result         (o_result),
        .o_divide_by_zero (o_divide_by_zero)
    );

endmodule
`default_nettype wire

### tb/sv/prime_field_alu_tb.sv
// Self-checking testbench for the prime field ALU: random ops over several moduli.
`timescale 1ns / 1ps
module prime_field_alu_tb;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] lhs;
        logic [31:0] rhs;
    } t_op_item;

    typedef struct {
        logic [30:0] value;
        logic        dz;
    } t_field_res;

    localparam longint TIMEOUT_CYCLES = 6000000;
    localparam int     HOLD_CYCLES    = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [30:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = pfa_pkg::OP_ADD;
    logic [31:0] i_left_operand = '0;
    logic [31:0] i_right_operand = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [30:0] o_result;
    logic        o_divide_by_zero;

    t_op_item   pending_ops[$];
    t_field_res expected_res[$];
    logic [30:0] field_mod = 31'h7FFF_FFFF;
    int  error_cnt = 0;
    int  result_cnt = 0;
    bit  quiet = 0;
    bit  hold_done = 0;
    int  hold_cnt = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    longint cycle_cnt = 0;

    prime_field_alu uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_op(i_op), .i_left_operand(i_left_operand), .i_right_operand(i_right_operand),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_result(o_result), .o_divide_by_zero(o_divide_by_zero)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint floor_mod(longint v, longint p);
        longint r;
        r = v % p;
        if (r < 0) r += p;
        return r;
    endfunction

    function automatic longint euclid_inverse(longint a, longint p);
        longint m, x0, x1, q, t;
        m = p; x0 = 0; x1 = 1;
        if (p == 1) return 0;
        while (a > 1 && m != 0) begin
            q = a / m;
            t = m;
            m = a % m;
            a = t;
            t = x0;
            x0 = x1 - q * x0;
            x1 = t;
        end
        return floor_mod(x1, p);
    endfunction

    function automatic t_field_res field_compute(t_op_item it, logic [30:0] modv);
        longint p, a, b, r;
        t_field_res res;
        p = (modv < 2) ? 1 : longint'(modv);
        a = floor_mod(longint'($signed(it.lhs)), p);
        b = floor_mod(longint'($signed(it.rhs)), p);
        res.dz = 1'b0;
        case (it.op)
            pfa_pkg::OP_ADD: r = (a + b) % p;
            pfa_pkg::OP_SUB: r = (a + p - b) % p;
            pfa_pkg::OP_MUL: r = (a * b) % p;
            default: begin
                if (b == 0) begin
                    res.dz = 1'b1;
                    r = 0;
                end else begin
                    r = (a * euclid_inverse(b, p)) % p;
                end
            end
        endcase
        res.value = r[30:0];
        return res;
    endfunction

    function automatic logic [31:0] rand_operand(logic [30:0] modv);
        logic [31:0] m;
        m = {1'b0, modv};
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $urandom_range(0, 20) - 10;
            3: return m * $urandom_range(0, 3) + $urandom_range(0, 2) - 1;
            4: return -(m * $urandom_range(1, 2)) + $urandom_range(0, 2) - 1;
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                                 : 32'h8000_0000 + $urandom_range(0, 3);
        endcase
    endfunction

    task automatic add_op(logic [1:0] op, logic [31:0] l, logic [31:0] r);
        t_op_item it;
        it.op = op; it.lhs = l; it.rhs = r;
        pending_ops.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_ops.size() != 0 || expected_res.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
    endtask

    task automatic write_modulus(logic [30:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        field_mod = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // driver: predict on each accepted transfer, then present the next item
    always @(posedge i_clk) begin
        t_op_item it;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                it.op = i_op; it.lhs = i_left_operand; it.rhs = i_right_operand;
                expected_res.push_back(field_compute(it, field_mod));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    in_gap <= $urandom_range(0, 7);
                    i_in_valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    it = pending_ops.pop_front();
                    i_op <= it.op;
                    i_left_operand <= it.lhs;
                    i_right_operand <= it.rhs;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each output transfer, drive receiver stall
    always @(posedge i_clk) begin
        t_field_res exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                result_cnt <= result_cnt + 1;
                if (expected_res.size() == 0) begin
                    $display("%0t: unexpected result %h dz %b", $time, o_result,
                             o_divide_by_zero);
                    error_cnt <= error_cnt + 1;
                end else begin
                    exp_r = expected_res.pop_front();
                    if (exp_r.value !== o_result || exp_r.dz !== o_divide_by_zero) begin
                        $display("%0t: mismatch expected %h dz %b, actual %h dz %b", $time,
                                 exp_r.value, exp_r.dz, o_result, o_divide_by_zero);
                        error_cnt <= error_cnt + 1;
                    end
                end
            end
            // one long hold-off early on so the input side backs up
            if (!hold_done && result_cnt == 20) begin
                hold_done <= 1'b1;
                hold_cnt <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_out_stall <= (hold_cnt > 1);
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_gap <= $urandom_range(0, 7);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > TIMEOUT_CYCLES) begin
            $display("prime_field_alu test failed");
            $finish;
        end
    end

    initial begin
        logic [30:0] moduli[10];
        logic [30:0] m;
        moduli = '{31'h7FFF_FFFF, 31'd2, 31'd1, 31'd0, 31'd3, 31'd65521,
                   31'd221, 31'h7FFF_FFFE, 31'd1000003, 31'h7FFF_FFFF};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, all ops, divide by zero on reset modulus
        add_op(pfa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_op(pfa_pkg::OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
        add_op(pfa_pkg::OP_SUB, 32'd0, 32'd1);
        add_op(pfa_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFE);
        add_op(pfa_pkg::OP_MUL, 32'h7FFF_FFFE, 32'h7FFF_FFFE);
        add_op(pfa_pkg::OP_MUL, 32'h8000_0000, 32'hFFFF_FFFF);
        add_op(pfa_pkg::OP_DIV, 32'd1, 32'd0);
        add_op(pfa_pkg::OP_DIV, 32'd5, 32'h7FFF_FFFF);
        add_op(pfa_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        add_op(pfa_pkg::OP_DIV, 32'd1, 32'd2);
        add_op(pfa_pkg::OP_DIV, 32'h7FFF_FFFE, 32'h8000_0000);
        add_op(pfa_pkg::OP_ADD, 32'd0, 32'd0);

        for (int ph = 0; ph < 10; ph++) begin
            if (ph != 0) begin
                wait_idle();
                write_modulus(moduli[ph]);
                if (ph == 9) quiet = 1;
            end
            m = field_mod;
            // divisor zero or a multiple of p, and divisor 13 (not coprime to p only for p = 221)
            add_op(pfa_pkg::OP_DIV, $urandom, 32'd0);
            add_op(pfa_pkg::OP_DIV, $urandom, {1'b0, m});
            add_op(pfa_pkg::OP_DIV, $urandom, 32'd13);
            for (int i = 0; i < 55; i++)
                add_op(2'($urandom_range(0, 3)), rand_operand(m), rand_operand(m));
        end
        wait_idle();
        if (error_cnt == 0)
            $display("prime_field_alu test passed");
        else
            $display("prime_field_alu test failed");
        $finish;
    end
endmodule

### filelist.f
rtl/pfa_pkg.sv
rtl/pfa_front.sv
rtl/pfa_back.sv
rtl/prime_field_alu.sv
tb/sv/prime_field_alu_tb.sv
